### rtl/ferc_pkg.sv
// ----------------------------------------------------------------------------
// ferc_pkg
// shared types and constants for the formula element ratio check
// ----------------------------------------------------------------------------
package ferc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned TotalWidth = 16;

  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  typedef enum logic [2:0] {
    EL_NONE,
    EL_C,
    EL_H,
    EL_N,
    EL_O,
    EL_OTHER
  } elem_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_formula;
  } chr_t;

  typedef struct packed {
    logic                  formula_ok;
    logic                  has_oxygen;
    logic [TotalWidth-1:0] carbon_total;
    logic [TotalWidth-1:0] hydrogen_total;
    logic [TotalWidth-1:0] nitrogen_total;
    logic [TotalWidth-1:0] oxygen_total;
  } res_t;

  function automatic elem_e elem_of(input logic [7:0] ch);
    elem_e e;
    unique case (ch)
      ChC:     e = EL_C;
      ChH:     e = EL_H;
      ChN:     e = EL_N;
      ChO:     e = EL_O;
      default: e = EL_OTHER;
    endcase
    return e;
  endfunction

endpackage

### rtl/ferc_in_stage.sv
// ----------------------------------------------------------------------------
// ferc_in_stage
// input register for one character transaction
// ----------------------------------------------------------------------------
module ferc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  ferc_pkg::chr_t chr_i,
  input  logic          advance_i,
  output logic          valid_o,
  output ferc_pkg::chr_t chr_o
);
  import ferc_pkg::*;

  logic valid_q;
  chr_t chr_q;
  logic take;

  assign stall_o = valid_q && !advance_i;
  assign take    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      chr_q <= chr_i;
    end
  end

  assign valid_o = valid_q;
  assign chr_o   = chr_q;

endmodule

### rtl/ferc_core.sv
// ----------------------------------------------------------------------------
// ferc_core
// parse state, count accumulation and ratio rules, one character per cycle while fire_i is high
// ----------------------------------------------------------------------------
module ferc_core #(
  parameter int unsigned COUNT_WIDTH = ferc_pkg::CountWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  ferc_pkg::chr_t chr_i,
  output ferc_pkg::res_t res_o
);
  import ferc_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CountMax = {CW{1'b1}};

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? CountMax : s[CW-1:0];
  endfunction

  elem_e         cur_q,  cur_d;
  logic          run_q,  run_d;
  logic [CW-1:0] pend_q, pend_d;
  logic [CW-1:0] c_q, h_q, n_q, o_q;
  logic [CW-1:0] c_d, h_d, n_d, o_d;
  logic          saw_q,  saw_d;

  logic          is_digit, is_upper, last;
  logic [3:0]    dval;
  logic [CW+3:0] mul10;
  logic [CW-1:0] pend_a;
  logic          run_a;
  elem_e         cur_a;
  elem_e         close1_el, close2_el;
  logic [CW-1:0] n1, n2;
  elem_e         cur_b;
  logic          run_b;
  logic [CW-1:0] pend_b;
  logic [CW-1:0] c1, h1, n1s, o1;
  logic [CW-1:0] cf, hf, nf, of;
  logic [CW+2:0] h_lim;
  logic [CW+1:0] o_lim;
  logic          ok;

  assign last     = chr_i.end_of_formula;
  assign is_digit = (chr_i.char_code >= ChZero) && (chr_i.char_code <= ChNine);
  assign is_upper = (chr_i.char_code >= ChUpA) && (chr_i.char_code <= ChUpZ);
  assign dval     = 4'(chr_i.char_code - ChZero);
  assign mul10    = {1'b0, pend_q, 3'b000} + {3'b000, pend_q, 1'b0} + (CW+4)'(dval);

  always_comb begin
    cur_a     = cur_q;
    run_a     = run_q;
    pend_a    = pend_q;
    close1_el = EL_NONE;
    n1        = (run_q && (pend_q != '0)) ? pend_q : CW'(1);
    if (cur_q != EL_NONE) begin
      if (is_digit) begin
        pend_a = (mul10[CW+3:CW] != '0) ? CountMax : mul10[CW-1:0];
        run_a  = 1'b1;
      end else begin
        close1_el = cur_q;
        cur_a     = EL_NONE;
        run_a     = 1'b0;
        pend_a    = '0;
      end
    end

    cur_b  = cur_a;
    run_b  = run_a;
    pend_b = pend_a;
    if (is_upper) begin
      cur_b  = elem_of(chr_i.char_code);
      run_b  = 1'b0;
      pend_b = '0;
    end

    close2_el = last ? cur_b : EL_NONE;
    n2        = (run_b && (pend_b != '0)) ? pend_b : CW'(1);
  end

  // first close: the element ended by this character
  assign c1  = sat_add(c_q, (close1_el == EL_C) ? n1 : '0);
  assign h1  = sat_add(h_q, (close1_el == EL_H) ? n1 : '0);
  assign n1s = sat_add(n_q, (close1_el == EL_N) ? n1 : '0);
  assign o1  = sat_add(o_q, (close1_el == EL_O) ? n1 : '0);

  // second close: the element still open at the end of the formula
  assign cf = sat_add(c1,  (close2_el == EL_C) ? n2 : '0);
  assign hf = sat_add(h1,  (close2_el == EL_H) ? n2 : '0);
  assign nf = sat_add(n1s, (close2_el == EL_N) ? n2 : '0);
  assign of = sat_add(o1,  (close2_el == EL_O) ? n2 : '0);

  assign saw_d = saw_q || (chr_i.char_code == ChO);

  assign h_lim = {1'b0, cf, 2'b00} + (CW+3)'(2);
  assign o_lim = {2'b00, cf} + {1'b0, cf, 1'b0};
  assign ok    = (cf != '0) && ((CW+3)'(hf) <= h_lim) && (nf <= cf) && ((CW+2)'(of) <= o_lim);

  always_comb begin
    if (last) begin
      cur_d  = EL_NONE;
      run_d  = 1'b0;
      pend_d = '0;
      c_d    = '0;
      h_d    = '0;
      n_d    = '0;
      o_d    = '0;
    end else begin
      cur_d  = cur_b;
      run_d  = run_b;
      pend_d = pend_b;
      c_d    = cf;
      h_d    = hf;
      n_d    = nf;
      o_d    = of;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= EL_NONE;
      run_q  <= 1'b0;
      pend_q <= '0;
      c_q    <= '0;
      h_q    <= '0;
      n_q    <= '0;
      o_q    <= '0;
      saw_q  <= 1'b0;
    end else if (fire_i) begin
      cur_q  <= cur_d;
      run_q  <= run_d;
      pend_q <= pend_d;
      c_q    <= c_d;
      h_q    <= h_d;
      n_q    <= n_d;
      o_q    <= o_d;
      saw_q  <= last ? 1'b0 : saw_d;
    end
  end

  always_comb begin
    res_o.formula_ok     = ok;
    res_o.has_oxygen     = saw_d;
    res_o.carbon_total   = TotalWidth'(cf);
    res_o.hydrogen_total = TotalWidth'(hf);
    res_o.nitrogen_total = TotalWidth'(nf);
    res_o.oxygen_total   = TotalWidth'(of);
  end

endmodule

### rtl/ferc_out_stage.sv
// ----------------------------------------------------------------------------
// ferc_out_stage
// result register holding one finished transaction until it is taken
// ----------------------------------------------------------------------------
module ferc_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ferc_pkg::res_t res_i,
  input  logic           stall_i,
  output logic           advance_o,
  output logic           valid_o,
  output ferc_pkg::res_t res_o
);
  import ferc_pkg::*;

  logic valid_q;
  res_t res_q;

  assign advance_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/formula_element_ratio_check_top.sv
// ----------------------------------------------------------------------------
// formula_element_ratio_check_top
// checks a chemical formula, one character per transaction, against element
// ratio rules and reports the C, H, N and O totals after the last character
//
//   channel  direction  handshake          payload
//   input    in         valid_i / stall_o  char_code_i, end_of_formula_i
//   result   out        valid_o / stall_i  formula_ok_o, has_oxygen_o, *_total_o
//
// one character per cycle while the result side does not stall; the result register
// loads, and valid_o rises, when the final character moves from the input register into the core
// the parse state and counts update in the core on each character that fires
// reset clears the parse state, counts and both valid flags
// a stall while a result waits holds the result register and, in the same
// cycle, a character held in the input register; nothing is dropped
// ----------------------------------------------------------------------------
module formula_element_ratio_check_top #(
  parameter int unsigned COUNT_WIDTH = ferc_pkg::CountWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [7:0]                      char_code_i,
  input  logic                            end_of_formula_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic                            formula_ok_o,
  output logic                            has_oxygen_o,
  output logic [ferc_pkg::TotalWidth-1:0] carbon_total_o,
  output logic [ferc_pkg::TotalWidth-1:0] hydrogen_total_o,
  output logic [ferc_pkg::TotalWidth-1:0] nitrogen_total_o,
  output logic [ferc_pkg::TotalWidth-1:0] oxygen_total_o
);
  import ferc_pkg::*;

  chr_t chr_in, chr_q;
  logic chr_valid;
  logic advance;
  logic fire;
  res_t res_d, res_q;

  assign chr_in.char_code      = char_code_i;
  assign chr_in.end_of_formula = end_of_formula_i;
  assign fire                  = chr_valid && advance;

  ferc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .stall_o   (stall_o),
    .chr_i     (chr_in),
    .advance_i (advance),
    .valid_o   (chr_valid),
    .chr_o     (chr_q)
  );

  ferc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .chr_i  (chr_q),
    .res_o  (res_d)
  );

  ferc_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire && chr_q.end_of_formula),
    .res_i     (res_d),
    .stall_i   (stall_i),
    .advance_o (advance),
    .valid_o   (valid_o),
    .res_o     (res_q)
  );

  assign formula_ok_o     = res_q.formula_ok;
  assign has_oxygen_o     = res_q.has_oxygen;
  assign carbon_total_o   = res_q.carbon_total;
  assign hydrogen_total_o = res_q.hydrogen_total;
  assign nitrogen_total_o = res_q.nitrogen_total;
  assign oxygen_total_o   = res_q.oxygen_total;

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for formula_element_ratio_check_top: formulas go in one character
// per transaction, with random idle cycles on the input and random stalls on
// the result side; a scoreboard parses the same characters, predicts the
// ratio verdict and element totals of every formula and checks each result
// ----------------------------------------------------------------------------
import ferc_pkg::*;

class formula_scoreboard;
  localparam longint unsigned CountMax = (64'd1 << CountWidth) - 1;

  elem_e           open_el;
  bit              in_digits;
  longint unsigned run_count;
  longint unsigned c_sum;
  longint unsigned h_sum;
  longint unsigned n_sum;
  longint unsigned o_sum;
  bit              saw_o;
  res_t            totals_q[$];
  int              errors;
  int              formulas_seen;
  int              chars_seen;

  function new();
    errors        = 0;
    formulas_seen = 0;
    chars_seen    = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    open_el   = EL_NONE;
    in_digits = 0;
    run_count = 0;
    c_sum     = 0;
    h_sum     = 0;
    n_sum     = 0;
    o_sum     = 0;
    saw_o     = 0;
  endfunction

  function longint unsigned sat_add(longint unsigned a, longint unsigned b);
    return (a + b > CountMax) ? CountMax : a + b;
  endfunction

  function elem_e element_for(logic [7:0] ch);
    if (ch == ChC) return EL_C;
    if (ch == ChH) return EL_H;
    if (ch == ChN) return EL_N;
    if (ch == ChO) return EL_O;
    return EL_OTHER;
  endfunction

  function void close_element();
    longint unsigned n;
    n = (in_digits && run_count != 0) ? run_count : 1;
    case (open_el)
      EL_C:    c_sum = sat_add(c_sum, n);
      EL_H:    h_sum = sat_add(h_sum, n);
      EL_N:    n_sum = sat_add(n_sum, n);
      EL_O:    o_sum = sat_add(o_sum, n);
      default: ;
    endcase
    open_el   = EL_NONE;
    in_digits = 0;
    run_count = 0;
  endfunction

  function void note_char(logic [7:0] ch, logic last);
    bit              digit;
    bit              upper;
    longint unsigned v;
    res_t            want;
    digit = (ch >= ChZero) && (ch <= ChNine);
    upper = (ch >= ChUpA) && (ch <= ChUpZ);
    chars_seen++;
    if (ch == ChO) saw_o = 1;
    if (open_el != EL_NONE) begin
      if (digit) begin
        v = run_count * 10 + longint'(ch - ChZero);
        run_count = (v > CountMax) ? CountMax : v;
        in_digits = 1;
      end else begin
        close_element();
      end
    end
    if (upper) begin
      open_el   = element_for(ch);
      in_digits = 0;
      run_count = 0;
    end
    if (!last) return;
    if (open_el != EL_NONE) close_element();
    want.formula_ok     = (c_sum > 0) && (h_sum <= 4 * c_sum + 2) &&
                          (n_sum <= c_sum) && (o_sum <= 3 * c_sum);
    want.has_oxygen     = saw_o;
    want.carbon_total   = TotalWidth'(c_sum);
    want.hydrogen_total = TotalWidth'(h_sum);
    want.nitrogen_total = TotalWidth'(n_sum);
    want.oxygen_total   = TotalWidth'(o_sum);
    totals_q = {totals_q, want};
    clear_parse();
  endfunction

  function bit waiting();
    return totals_q.size() != 0;
  endfunction

  task report(string what);
    errors++;
    $display("tb: mismatch: %s", what);
  endtask

  task cmp(string name, longint unsigned got, longint unsigned want);
    if (got != want)
      report($sformatf("formula %0d %s got %0d expected %0d", formulas_seen, name, got, want));
  endtask

  task check_report(res_t got);
    res_t want;
    if (totals_q.size() == 0) begin
      report("result with no formula pending");
      return;
    end
    want = totals_q.pop_front();
    formulas_seen++;
    cmp("formula_ok", got.formula_ok, want.formula_ok);
    cmp("has_oxygen", got.has_oxygen, want.has_oxygen);
    cmp("carbon_total", got.carbon_total, want.carbon_total);
    cmp("hydrogen_total", got.hydrogen_total, want.hydrogen_total);
    cmp("nitrogen_total", got.nitrogen_total, want.nitrogen_total);
    cmp("oxygen_total", got.oxygen_total, want.oxygen_total);
  endtask
endclass

module tb;
  localparam int Limit      = 200000;
  localparam int RandChars  = 450;
  localparam int DrainTicks = 8;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  valid_i          = 1'b0;
  logic                  stall_o;
  logic [7:0]            char_code_i      = 8'h00;
  logic                  end_of_formula_i = 1'b0;
  logic                  valid_o;
  logic                  stall_i          = 1'b0;
  logic                  formula_ok_o;
  logic                  has_oxygen_o;
  logic [TotalWidth-1:0] carbon_total_o;
  logic [TotalWidth-1:0] hydrogen_total_o;
  logic [TotalWidth-1:0] nitrogen_total_o;
  logic [TotalWidth-1:0] oxygen_total_o;

  formula_scoreboard sb = new();
  logic [7:0]        formula_text[$];
  bit                calm = 1'b0;
  int                cycle_count = 0;

  formula_element_ratio_check_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .char_code_i      (char_code_i),
    .end_of_formula_i (end_of_formula_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .formula_ok_o     (formula_ok_o),
    .has_oxygen_o     (has_oxygen_o),
    .carbon_total_o   (carbon_total_o),
    .hydrogen_total_o (hydrogen_total_o),
    .nitrogen_total_o (nitrogen_total_o),
    .oxygen_total_o   (oxygen_total_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < Limit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles", Limit);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      stall_i <= !calm && ($urandom_range(99) < 16);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o && !stall_i)
        sb.check_report({formula_ok_o, has_oxygen_o, carbon_total_o,
                         hydrogen_total_o, nitrogen_total_o, oxygen_total_o});
    end
  end

  function automatic void add_char(input logic [7:0] ch);
    formula_text = {formula_text, ch};
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    while (!calm && $urandom_range(99) < 16) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i          <= 1'b1;
    char_code_i      <= ch;
    end_of_formula_i <= last;
    do @(posedge clk_i); while (stall_o);
    sb.note_char(ch, last);
  endtask

  task automatic send_formula();
    foreach (formula_text[i]) send_char(formula_text[i], i == formula_text.size() - 1);
  endtask

  task automatic send_text(input string s);
    formula_text.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_formula();
  endtask

  task automatic hold_until_drained();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.waiting()) @(posedge clk_i);
  endtask

  task automatic push_digits();
    int r;
    int ndig;
    r = $urandom_range(99);
    ndig = (r < 35) ? 0 : (r < 88) ? 1 : (r < 97) ? 2 : 6;
    repeat (ndig) add_char(8'($urandom_range(ChNine, ChZero)));
  endtask

  task automatic make_random_formula();
    formula_text.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(6, 1)) add_char(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(9))
        0, 1, 2: add_char(ChC);
        3, 4:    add_char(ChH);
        5:       add_char(ChN);
        6:       add_char(ChO);
        7:       add_char(8'($urandom_range(ChUpZ, ChUpA)));
        8: begin
          add_char(ChC);
          add_char(8'($urandom_range(8'h7a, 8'h61)));
        end
        default: add_char(8'($urandom_range(255)));
      endcase
      push_digits();
      if ($urandom_range(99) < 5) add_char(8'($urandom_range(255)));
    end
  endtask

  initial begin
    bit paused = 1'b0;
    int start_chars;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge cases: lone carbon, zero count, hydrogen bound, lowercase skip,
    // count and sum saturation, no element, extreme byte values
    send_text("C");
    send_text("C0");
    send_text("CH6");
    send_text("CH7");
    send_text("Cl2O");
    send_text("C99999C9N");
    send_text("-");
    formula_text.delete();
    add_char(8'h00);
    add_char(ChO);
    add_char(8'hFF);
    send_formula();
    hold_until_drained();

    start_chars = sb.chars_seen;
    while (sb.chars_seen - start_chars < RandChars) begin
      calm = (sb.chars_seen - start_chars >= 150) && (sb.chars_seen - start_chars < 300);
      if (!paused && sb.chars_seen - start_chars >= 225) begin
        paused = 1'b1;
        hold_until_drained();
      end
      make_random_formula();
      send_formula();
    end
    calm = 1'b0;
    valid_i <= 1'b0;

    while (sb.waiting()) @(posedge clk_i);
    repeat (DrainTicks) @(posedge clk_i);

    $display("tb: %0d formulas, %0d characters through the ratio check",
             sb.formulas_seen, sb.chars_seen);
    $display("tb: covered zero and saturating counts, skipped and lowercase characters");
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
